// ===== rtl/dtw_pkg.sv =====
// Shared types and constants for the path engine.
package dtw_pkg;
	localparam int CostBits = 22;
	localparam logic [CostBits-1:0] CostMax = {CostBits{1'b1}};
	localparam int FrameBits = 16;
	localparam int CountBits = 6;
	localparam int CfgIdxBits = 2;

	localparam logic [CfgIdxBits-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [CfgIdxBits-1:0] REG_COL_COUNT = 2'd1;
	localparam logic [CfgIdxBits-1:0] REG_FIRST_START = 2'd2;
	localparam logic [CfgIdxBits-1:0] REG_SECOND_START = 2'd3;

	typedef logic [CostBits-1:0] cost_t;

	// Saturating add of two costs.
	function automatic cost_t sat_add(input cost_t a, input cost_t b);
		logic [CostBits:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CostBits] ? CostMax : s[CostBits-1:0];
	endfunction

	function automatic cost_t min2(input cost_t a, input cost_t b);
		return (a < b) ? a : b;
	endfunction
endpackage

// ===== rtl/dtw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dtw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end
endmodule

// ===== rtl/dtw_cell.sv =====
// One column cell: holds the cost of the row above and of its own column.
module dtw_cell
	import dtw_pkg::*;
(
	input  logic  clk,
	input  logic  step,      // a new cell value enters this column
	input  logic  first_row,
	input  logic  first_col,
	input  cost_t cell_dist,
	input  cost_t left_cost, // cost just computed in the column to the left
	input  cost_t diag_cost, // up-cost of the column to the left (old row)
	output cost_t up_q,      // cost of this column in the last finished row
	output cost_t new_cost
);
	cost_t prev;

	// Predecessor choice for the cumulative recurrence.
	always_comb begin
		if (first_row && first_col) prev = '0;
		else if (first_row) prev = left_cost;
		else if (first_col) prev = up_q;
		else prev = min2(min2(up_q, left_cost), diag_cost);
		new_cost = sat_add(prev, cell_dist);
	end

	always_ff @(posedge clk) begin
		if (step) up_q <= new_cost;
	end
endmodule

// ===== rtl/dtw_path_engine.sv =====
// Top level: loads the distance matrix, fills costs through a column cell row, traces back.
// Entries load one per cycle while the engine is in its load state. On the last entry the
// cost table is filled cell by cell (distance RAM read, then a column cell of the row of
// MAX_COLS cells computes and hands its cost to the right neighbor).
// Traceback emits one pair per cycle along the first row or first column, unless m_tready
// stalls it; elsewhere it reads up, left and diagonal costs from the cost RAM one per cycle
// and then emits one pair (plus output handshake stalls); at most rows+cols-1 pairs.
// No item is accepted from the last entry until the final pair is taken.
module dtw_path_engine
	import dtw_pkg::*;
#(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32,
	parameter int DIST_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // distance_value[15:0]
	input  logic                  s_tlast,   // last_entry
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [55:0]           m_tdata,   // first_frame, second_frame, path_cost, pad
	output logic                  m_tlast,   // path_last
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CfgIdxBits-1:0] cfg_index,
	input  logic [FrameBits-1:0]  cfg_data
);
	localparam int Depth = MAX_ROWS * MAX_COLS;
	localparam int AddrBits = $clog2(Depth);
	localparam int RowBits = $clog2(MAX_ROWS);
	localparam int ColBits = $clog2(MAX_COLS);
	localparam int DB = (DIST_BITS < 16) ? DIST_BITS : 16;
	localparam logic [15:0] DistMask = 16'((17'd1 << DB) - 17'd1);

	localparam logic [2:0] ST_LOAD = 3'd0, ST_FRD = 3'd1, ST_FCALC = 3'd2,
		ST_TUP = 3'd3, ST_TLEFT = 3'd4, ST_TDIAG = 3'd5, ST_TDEC = 3'd6,
		ST_OUT = 3'd7;

	logic [2:0] state_q;
	logic [CountBits-1:0] row_cfg_q, col_cfg_q;
	logic [FrameBits-1:0] first_start_q, second_start_q;
	logic [AddrBits:0] load_pos_q;
	logic [RowBits-1:0] r_q, ti_q;
	logic [ColBits-1:0] c_q, tj_q;
	cost_t corner_q, up_val_q, left_val_q;
	cost_t last_cost_q; // cost just produced (left neighbor value)

	// Clamped sizes.
	logic [RowBits:0] rows;
	logic [ColBits:0] cols;
	logic [AddrBits:0] total;
	always_comb begin
		if (row_cfg_q == '0) rows = (RowBits+1)'(1);
		else if ({1'b0, row_cfg_q} > 7'(MAX_ROWS)) rows = (RowBits+1)'(MAX_ROWS);
		else rows = (RowBits+1)'(row_cfg_q);
		if (col_cfg_q == '0) cols = (ColBits+1)'(1);
		else if ({1'b0, col_cfg_q} > 7'(MAX_COLS)) cols = (ColBits+1)'(MAX_COLS);
		else cols = (ColBits+1)'(col_cfg_q);
		total = (AddrBits+1)'(rows) * (AddrBits+1)'(cols);
	end

	function automatic logic [AddrBits-1:0] addr_of(input logic [RowBits-1:0] r,
			input logic [ColBits-1:0] c, input logic [ColBits:0] n);
		return AddrBits'(r) * AddrBits'(n) + AddrBits'(c);
	endfunction

	// Configuration writes.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cfg_q <= 6'd32;
			col_cfg_q <= 6'd32;
			first_start_q <= '0;
			second_start_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW_COUNT:    row_cfg_q <= cfg_data[CountBits-1:0];
				REG_COL_COUNT:    col_cfg_q <= cfg_data[CountBits-1:0];
				REG_FIRST_START:  first_start_q <= cfg_data;
				REG_SECOND_START: second_start_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Memories.
	logic dw_en, cw_en;
	logic [AddrBits-1:0] dw_addr, dr_addr, cr_addr;
	logic [15:0] d_rd;
	cost_t c_rd, cell_out;
	logic s_fire;
	assign s_tready = (state_q == ST_LOAD);
	assign s_fire = s_tvalid && s_tready;
	assign dw_en = s_fire && (load_pos_q < total);
	assign dw_addr = load_pos_q[AddrBits-1:0];
	assign dr_addr = addr_of(r_q, c_q, cols);

	dtw_ram #(.WIDTH(16), .DEPTH(Depth)) u_dist (
		.clk, .wr_en(dw_en), .wr_addr(dw_addr), .wr_data(s_tdata & DistMask),
		.rd_addr(dr_addr), .rd_data(d_rd));

	assign cw_en = (state_q == ST_FCALC);
	dtw_ram #(.WIDTH(CostBits), .DEPTH(Depth)) u_cost (
		.clk, .wr_en(cw_en), .wr_addr(dr_addr), .wr_data(cell_out),
		.rd_addr(cr_addr), .rd_data(c_rd));

	// Old up-value of the current column, captured before it updates; it is the
	// diagonal cost for the next column of the same row.
	cost_t diag_hold_q;

	// Row of column cells; each column keeps the cost of the row above.
	cost_t up_arr [MAX_COLS];
	cost_t new_arr [MAX_COLS];
	genvar g;
	generate
		for (g = 0; g < MAX_COLS; g++) begin : g_col
			dtw_cell u_cell (
				.clk,
				.step(cw_en && (c_q == ColBits'(g))),
				.first_row(r_q == '0),
				.first_col(g == 0),
				.cell_dist({6'd0, d_rd}),
				.left_cost(last_cost_q),
				.diag_cost(diag_hold_q),
				.up_q(up_arr[g]),
				.new_cost(new_arr[g]));
		end
	endgenerate
	assign cell_out = new_arr[c_q];

	// Traceback read address.
	always_comb begin
		unique case (state_q)
			ST_TUP:   cr_addr = addr_of(ti_q - 1'b1, tj_q, cols);
			ST_TLEFT: cr_addr = addr_of(ti_q, tj_q - 1'b1, cols);
			ST_TDIAG: cr_addr = addr_of(ti_q - 1'b1, tj_q - 1'b1, cols);
			default:  cr_addr = addr_of(ti_q, tj_q, cols);
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			load_pos_q <= '0;
			r_q <= '0;
			c_q <= '0;
			ti_q <= '0;
			tj_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: if (s_fire) begin
					if (s_tlast) begin
						load_pos_q <= '0;
						r_q <= '0;
						c_q <= '0;
						state_q <= ST_FRD;
					end else if (load_pos_q < total) begin
						load_pos_q <= load_pos_q + 1'b1;
					end
				end
				ST_FRD: state_q <= ST_FCALC;
				ST_FCALC: begin
					if ({1'b0, c_q} == cols - 1'b1) begin
						c_q <= '0;
						if ({1'b0, r_q} == rows - 1'b1) begin
							ti_q <= r_q;
							tj_q <= c_q;
							state_q <= ST_OUT;
						end else begin
							r_q <= r_q + 1'b1;
							state_q <= ST_FRD;
						end
					end else begin
						c_q <= c_q + 1'b1;
						state_q <= ST_FRD;
					end
				end
				ST_OUT: if (m_tready) begin
					if (ti_q == '0 && tj_q == '0) state_q <= ST_LOAD;
					else if (ti_q == '0) begin
						tj_q <= tj_q - 1'b1;
					end else if (tj_q == '0) begin
						ti_q <= ti_q - 1'b1;
					end else state_q <= ST_TUP;
				end
				ST_TUP:   state_q <= ST_TLEFT;
				ST_TLEFT: state_q <= ST_TDIAG;
				ST_TDIAG: state_q <= ST_TDEC;
				ST_TDEC: begin
					// c_rd holds diagonal now.
					if (up_val_q <= left_val_q && up_val_q <= c_rd) ti_q <= ti_q - 1'b1;
					else if (left_val_q <= c_rd) tj_q <= tj_q - 1'b1;
					else begin
						ti_q <= ti_q - 1'b1;
						tj_q <= tj_q - 1'b1;
					end
					state_q <= ST_OUT;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_FCALC) begin
			last_cost_q <= cell_out;
			corner_q <= cell_out;
			diag_hold_q <= up_arr[c_q];
		end
		if (state_q == ST_TLEFT) up_val_q <= c_rd;
		if (state_q == ST_TDIAG) left_val_q <= c_rd;
	end

	// Output.
	logic [FrameBits-1:0] ff, sf;
	assign ff = FrameBits'(ti_q) + first_start_q;
	assign sf = FrameBits'(tj_q) + second_start_q;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = {2'b00, corner_q, sf, ff};
	assign m_tlast = (ti_q == '0) && (tj_q == '0);

	a_no_input_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !s_tready) else $error("input taken during run");
	a_tlast_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (state_q == ST_LOAD)) else $error("path overrun");
endmodule
